[rtl/ppfm_pkg.sv]
// Package for the primer pair fragment matcher.
// Holds field widths, the request and result beat structs, table entry types
// and the sequencer state type. Depends on nothing.
`default_nettype none

package ppfm_pkg;

  // Field widths
  localparam int COORD_BITS = 24;
  localparam int REF_BITS   = 8;
  localparam int TAG_BITS   = 16;
  localparam int SLOT_BITS  = 5;
  localparam int GAP_BITS   = COORD_BITS + 1;
  // Signed width for the gap arithmetic: covers -len .. 3*len
  localparam int DIST_BITS  = COORD_BITS + 3;
  // Remainder unit step counter, counts 0 .. COORD_BITS
  localparam int STEP_BITS  = $clog2(COORD_BITS + 1);

  // Defaults for the top level parameters
  localparam int PRIMER_SLOTS_DEF = 32;
  localparam int MAX_PAIRS_DEF    = 64;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [REF_BITS-1:0]   ref_t;
  typedef logic [TAG_BITS-1:0]   tag_t;
  typedef logic [GAP_BITS-1:0]   gap_t;
  typedef logic [DIST_BITS-1:0]  dist_t;
  typedef logic [STEP_BITS-1:0]  step_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_t;

  // One request beat
  typedef struct packed {
    req_kind_t              req_type;
    logic [SLOT_BITS-1:0]   primer_slot;
    ref_t                   primer_ref;
    coord_t                 primer_start;
    coord_t                 primer_end;
    logic                   primer_is_reverse;
    ref_t                   frag_ref;
    coord_t                 frag_start;
    coord_t                 frag_end;
    coord_t                 ref_len;
    tag_t                   frag_tag;
  } ppfm_req_t;

  // One result beat
  typedef struct packed {
    tag_t   out_tag;
    coord_t fwd_pos;
    coord_t rev_pos;
    gap_t   gap;
    logic   last_pair;
    logic   pairs_dropped;
  } ppfm_pair_t;

  // Primer table entry
  typedef struct packed {
    ref_t   sref;
    logic   rev;
    coord_t pos;
  } ppfm_slot_t;

  // Pair buffer entry, positions not yet reduced
  typedef struct packed {
    coord_t fpos;
    coord_t rpos;
    gap_t   gap;
  } ppfm_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FWD_RD,
    ST_FWD_EVAL,
    ST_REV,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_MOD_F,
    ST_MOD_R,
    ST_OUT
  } ppfm_state_t;

endpackage

`default_nettype wire

[rtl/primer_pair_fragment_match.sv]
// Primer pair fragment matcher: primer table, pair walk, pair buffer, emit.
// Uses ppfm_pkg for types and widths.
// A query, N = PRIMER_SLOTS: presence scan of N slots, forward walk with a reverse
//   walk (N slots, or the fragment end alone with no reverse primer) per forward
//   primer inside the fragment, then per emitted pair a reduction of both
//   positions and an output beat held by stall. One item at a time: a query
// holds off input for all of it, a load does not. Reset (rst, synchronous)
// empties the primer table and clears min_distance; no clearing pass is needed.
`default_nettype none

module primer_pair_fragment_match #(
  parameter int PRIMER_SLOTS = ppfm_pkg::PRIMER_SLOTS_DEF,
  parameter int MAX_PAIRS    = ppfm_pkg::MAX_PAIRS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output      logic                   req_stall,
  input  wire ppfm_pkg::ppfm_req_t    req,
  output      logic                   pair_valid,
  input  wire logic                   pair_stall,
  output      ppfm_pkg::ppfm_pair_t   pair,
  input  wire logic                   cfg_wr_en,
  input  wire ppfm_pkg::coord_t       cfg_wr_data
);

  localparam int SLOT_W = (PRIMER_SLOTS > 1) ? $clog2(PRIMER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(PRIMER_SLOTS + 1);
  localparam int IDX_W  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int PCNT_W = $clog2(MAX_PAIRS + 1);
  localparam int CB     = ppfm_pkg::COORD_BITS;
  localparam int DB     = ppfm_pkg::DIST_BITS;

  localparam logic [CNT_W-1:0]  NSLOT   = CNT_W'(PRIMER_SLOTS);
  localparam logic [CNT_W-1:0]  ONE_CNT = CNT_W'(1);
  localparam logic [PCNT_W-1:0] NPAIR   = PCNT_W'(MAX_PAIRS);
  localparam ppfm_pkg::step_t   LAST_STEP = ppfm_pkg::STEP_BITS'(CB);

  // Position inside the fragment; circular fragments wrap
  function automatic logic inside_frag(ppfm_pkg::coord_t p, ppfm_pkg::coord_t s,
                                       ppfm_pkg::coord_t e, logic circ);
    logic ge_s;
    logic le_e;
    ge_s = (p >= s);
    le_e = (p <= e);
    return circ ? (ge_s || le_e) : (ge_s && le_e);
  endfunction

  // Reported position: remainder, zero shown as the length, no wrap if len is 0
  function automatic ppfm_pkg::coord_t wrap_rep(ppfm_pkg::coord_t r, ppfm_pkg::coord_t x,
                                                ppfm_pkg::coord_t len);
    ppfm_pkg::coord_t v;
    if (len == '0) begin
      v = x;
    end else if (r == '0) begin
      v = len;
    end else begin
      v = r;
    end
    return v;
  endfunction

  ppfm_pkg::ppfm_state_t state, state_next;

  // Config register
  ppfm_pkg::coord_t min_distance;

  // Query context
  ppfm_pkg::ref_t   fref;
  ppfm_pkg::coord_t s_r, e_r, len_r;
  ppfm_pkg::tag_t   tag_r;
  logic             circ_r;
  logic             has_f, has_r;

  // Walk counters
  logic [CNT_W-1:0] cnt, fcnt;
  logic [CNT_W-1:0] nf, nr, fcnt_inc;
  logic             fwd_last;
  ppfm_pkg::coord_t fpos_r;

  // Primer table
  ppfm_pkg::ppfm_slot_t     slot_mem [PRIMER_SLOTS];
  logic [PRIMER_SLOTS-1:0]  slot_valid;
  ppfm_pkg::ppfm_slot_t     slot_q;
  logic                     valid_q;
  logic [SLOT_W-1:0]        rd_addr;
  logic                     issue, pend;
  logic                     ld_en;

  // Pair pipeline
  logic               p1_v, p2_v;
  ppfm_pkg::coord_t   p1_rpos, p2_rpos;
  ppfm_pkg::dist_t    p1_d0, p2_d;
  logic               e_cand;
  ppfm_pkg::coord_t   e_rpos;
  ppfm_pkg::dist_t    d_a, d_b, d_sel;
  logic               p2_ok;
  logic               pipe_busy;

  // Pair buffer
  ppfm_pkg::ppfm_res_t res_mem [MAX_PAIRS];
  ppfm_pkg::ppfm_res_t buf_q;
  logic [PCNT_W-1:0]   count, k, k_inc;
  logic                dropped;
  logic                buf_we;

  // Remainder unit
  ppfm_pkg::coord_t  rem, sh;
  ppfm_pkg::step_t   step;
  logic [CB:0]       rem_t;
  ppfm_pkg::coord_t  rem_step;
  ppfm_pkg::coord_t  fwd_rep;

  logic fwd_hit;
  logic walk_done_empty;
  logic q_accept;

  // Derived control
  assign nf       = has_f ? NSLOT : ONE_CNT;
  assign nr       = has_r ? NSLOT : ONE_CNT;
  assign fcnt_inc = fcnt + ONE_CNT;
  assign fwd_last = (fcnt_inc == nf);
  assign k_inc    = k + PCNT_W'(1);
  assign pipe_busy = pend || p1_v || p2_v;
  assign walk_done_empty = (count == '0);
  assign q_accept = req_valid && !req_stall && (req.req_type == ppfm_pkg::REQ_QUERY);
  assign ld_en    = req_valid && !req_stall && (req.req_type == ppfm_pkg::REQ_LOAD) &&
                    (32'(req.primer_slot) < PRIMER_SLOTS);

  // Forward candidate check on the registered table read
  always_comb begin
    ppfm_pkg::coord_t fp;
    logic cand;
    cand = has_f ? (valid_q && !slot_q.rev && (slot_q.sref == fref)) : 1'b1;
    fp   = has_f ? slot_q.pos : s_r;
    fwd_hit = cand && inside_frag(fp, s_r, e_r, circ_r);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ppfm_pkg::ST_IDLE: begin
        if (q_accept) state_next = ppfm_pkg::ST_SCAN;
      end
      ppfm_pkg::ST_SCAN: begin
        if (cnt == NSLOT && !pend) state_next = ppfm_pkg::ST_FWD_RD;
      end
      ppfm_pkg::ST_FWD_RD: state_next = ppfm_pkg::ST_FWD_EVAL;
      ppfm_pkg::ST_FWD_EVAL: begin
        if (fwd_hit) begin
          state_next = ppfm_pkg::ST_REV;
        end else if (fwd_last) begin
          state_next = walk_done_empty ? ppfm_pkg::ST_IDLE : ppfm_pkg::ST_EMIT_RD;
        end else begin
          state_next = ppfm_pkg::ST_FWD_RD;
        end
      end
      ppfm_pkg::ST_REV: begin
        if (cnt == nr && !pipe_busy) begin
          if (!fwd_last) begin
            state_next = ppfm_pkg::ST_FWD_RD;
          end else begin
            state_next = walk_done_empty ? ppfm_pkg::ST_IDLE : ppfm_pkg::ST_EMIT_RD;
          end
        end
      end
      ppfm_pkg::ST_EMIT_RD: state_next = ppfm_pkg::ST_EMIT_LD;
      ppfm_pkg::ST_EMIT_LD: state_next = ppfm_pkg::ST_MOD_F;
      ppfm_pkg::ST_MOD_F: begin
        if (step == LAST_STEP) state_next = ppfm_pkg::ST_MOD_R;
      end
      ppfm_pkg::ST_MOD_R: begin
        if (step == LAST_STEP) state_next = ppfm_pkg::ST_OUT;
      end
      ppfm_pkg::ST_OUT: begin
        if (!pair_stall) begin
          state_next = (k_inc == count) ? ppfm_pkg::ST_IDLE : ppfm_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = ppfm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_stall  = (state != ppfm_pkg::ST_IDLE);
    pair_valid = (state == ppfm_pkg::ST_OUT);
    issue      = 1'b0;
    rd_addr    = cnt[SLOT_W-1:0];
    unique case (state)
      ppfm_pkg::ST_SCAN:   issue = (cnt != NSLOT);
      ppfm_pkg::ST_REV:    issue = (cnt != nr);
      ppfm_pkg::ST_FWD_RD: begin
        issue   = 1'b1;
        rd_addr = fcnt[SLOT_W-1:0];
      end
      default: issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppfm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= '0;
    end else if (cfg_wr_en) begin
      min_distance <= cfg_wr_data;
    end
  end

  // Primer table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ld_en) begin
      slot_mem[SLOT_W'(req.primer_slot)] <= '{
        sref: req.primer_ref,
        rev:  req.primer_is_reverse,
        pos:  req.primer_is_reverse ? req.primer_start : req.primer_end
      };
    end
    slot_q  <= slot_mem[rd_addr];
    valid_q <= slot_valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (ld_en) begin
      slot_valid[SLOT_W'(req.primer_slot)] <= 1'b1;
    end
  end

  // Query capture, presence scan and walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 1'b0;
      has_f   <= 1'b0;
      has_r   <= 1'b0;
      cnt     <= '0;
      fcnt    <= '0;
    end else begin
      pend <= issue;
      if (q_accept) begin
        has_f <= 1'b0;
        has_r <= 1'b0;
        cnt   <= '0;
        fcnt  <= '0;
      end
      if (issue && state != ppfm_pkg::ST_FWD_RD) cnt <= cnt + ONE_CNT;
      // Presence of forward and reverse primers on this reference
      if (state == ppfm_pkg::ST_SCAN && pend && valid_q && slot_q.sref == fref) begin
        if (slot_q.rev) has_r <= 1'b1;
        else            has_f <= 1'b1;
      end
      if (state == ppfm_pkg::ST_FWD_EVAL) begin
        if (fwd_hit) cnt  <= '0;
        else         fcnt <= fcnt_inc;
      end
      if (state == ppfm_pkg::ST_REV && cnt == nr && !pipe_busy) fcnt <= fcnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (q_accept) begin
      fref   <= req.frag_ref;
      len_r  <= req.ref_len;
      tag_r  <= req.frag_tag;
      circ_r <= (req.frag_start > req.frag_end);
      s_r    <= (req.frag_start > req.frag_end && req.frag_start == '0) ?
                req.ref_len : req.frag_start;
      e_r    <= (req.frag_start > req.frag_end && req.frag_end == '0) ?
                ppfm_pkg::COORD_BITS'(1) : req.frag_end;
    end
    if (state == ppfm_pkg::ST_FWD_EVAL && fwd_hit) begin
      fpos_r <= has_f ? slot_q.pos : s_r;
    end
  end

  // Reverse candidate from the table read, or the fragment end as stand-in
  assign e_cand = has_r ? (valid_q && slot_q.rev && (slot_q.sref == fref)) : 1'b1;
  assign e_rpos = has_r ? slot_q.pos : e_r;

  // Gap: d0 + len when the pair wraps or d0 is negative, once more if a wrapping pair needs it
  assign d_a = p1_d0 + DB'(len_r);
  assign d_b = p1_d0 + DB'({len_r, 1'b0});
  always_comb begin
    if (circ_r && p1_d0[DB-1]) begin
      d_sel = d_a[DB-1] ? d_b : d_a;
    end else begin
      d_sel = p1_d0[DB-1] ? d_a : p1_d0;
    end
  end

  assign p2_ok  = p2_v && !p2_d[DB-1] && (p2_d[DB-2:0] >= (DB-1)'(min_distance));
  assign buf_we = p2_ok && (count < NPAIR);

  // Pair pipeline: candidate and d0, gap select, threshold and store
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v    <= 1'b0;
      p2_v    <= 1'b0;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      p1_v <= (state == ppfm_pkg::ST_REV) && pend && e_cand &&
              inside_frag(e_rpos, s_r, e_r, circ_r);
      p2_v <= p1_v;
      if (q_accept) begin
        count   <= '0;
        dropped <= 1'b0;
      end else if (buf_we) begin
        count <= count + PCNT_W'(1);
      end else if (p2_ok) begin
        dropped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_rpos <= e_rpos;
    p1_d0   <= DB'(e_rpos) - DB'(fpos_r);
    p2_rpos <= p1_rpos;
    p2_d    <= d_sel;
  end

  // Pair buffer: write at the fill count, registered read at the emit index
  always_ff @(posedge clk) begin
    if (buf_we) begin
      res_mem[count[IDX_W-1:0]] <= '{
        fpos: fpos_r,
        rpos: p2_rpos,
        gap:  p2_d[ppfm_pkg::GAP_BITS-1:0]
      };
    end
    buf_q <= res_mem[k[IDX_W-1:0]];
  end

  // Emit index
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (state == ppfm_pkg::ST_IDLE) begin
      k <= '0;
    end else if (state == ppfm_pkg::ST_OUT && !pair_stall) begin
      k <= k_inc;
    end
  end

  // Remainder unit: restoring, one dividend bit a cycle
  assign rem_t    = {rem, sh[CB-1]};
  assign rem_step = (rem_t >= {1'b0, len_r}) ? CB'(rem_t - {1'b0, len_r}) : rem_t[CB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == ppfm_pkg::ST_EMIT_LD) begin
      step <= '0;
    end else if (state == ppfm_pkg::ST_MOD_F || state == ppfm_pkg::ST_MOD_R) begin
      step <= (step == LAST_STEP) ? '0 : step + ppfm_pkg::STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ppfm_pkg::ST_EMIT_LD: begin
        sh  <= buf_q.fpos;
        rem <= '0;
      end
      ppfm_pkg::ST_MOD_F: begin
        if (step == LAST_STEP) begin
          fwd_rep <= wrap_rep(rem, buf_q.fpos, len_r);
          sh      <= buf_q.rpos;
          rem     <= '0;
        end else begin
          rem <= rem_step;
          sh  <= {sh[CB-2:0], 1'b0};
        end
      end
      ppfm_pkg::ST_MOD_R: begin
        if (step == LAST_STEP) begin
          pair <= '{
            out_tag:       tag_r,
            fwd_pos:       fwd_rep,
            rev_pos:       wrap_rep(rem, buf_q.rpos, len_r),
            gap:           buf_q.gap,
            last_pair:     (k_inc == count),
            pairs_dropped: dropped
          };
        end else begin
          rem <= rem_step;
          sh  <= {sh[CB-2:0], 1'b0};
        end
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/ppfm_checker.sv]
// Port-level checks for the primer pair fragment matcher, bound to the top.
// Uses ppfm_pkg for the beat structs.
`default_nettype none

module ppfm_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  req_valid,
  input wire logic                  req_stall,
  input wire ppfm_pkg::ppfm_req_t   req,
  input wire logic                  pair_valid,
  input wire logic                  pair_stall,
  input wire ppfm_pkg::ppfm_pair_t  pair,
  input wire logic                  cfg_wr_en,
  input wire ppfm_pkg::coord_t      cfg_wr_data
);

  // A stalled result beat holds
  a_pair_hold: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair_stall |=> pair_valid && $stable(pair))
    else $error("result beat changed under stall");

  // No request is taken while a result is shown
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    pair_valid |-> req_stall)
    else $error("request accepted while result pending");

  // A query occupies the block on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.req_type == ppfm_pkg::REQ_QUERY |=> req_stall)
    else $error("block free right after a query");

  // A primer load leaves the block free on the next cycle
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.req_type == ppfm_pkg::REQ_LOAD |=> !req_stall)
    else $error("block busy after a primer load");

endmodule

bind primer_pair_fragment_match ppfm_checker u_ppfm_checker (.*);

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench for primer_pair_fragment_match: primer loads and fragment queries go in,
// and every pair beat is checked against a scoreboard that predicts the pair walk.
// Depends on rtl/ppfm_pkg.sv and rtl/primer_pair_fragment_match.sv.

module tb;

  localparam int SLOTS        = ppfm_pkg::PRIMER_SLOTS_DEF;
  localparam int PAIR_CAP     = ppfm_pkg::MAX_PAIRS_DEF;
  localparam int DRAIN_CYCLES = 1500;   // longest query walk with no pair beat
  localparam int HOLD_CYCLES  = 2000;   // outlasts a full-table walk
  localparam int STALL_LIMIT  = 20000;
  localparam int PHASE_ITEMS  = 45;
  localparam int COORD_MAX    = 24'hFFFFFF;

  // Predicts the pair beats of each fragment query and holds them in order
  class pair_scoreboard;
    ppfm_pkg::coord_t     min_gap;
    bit                   slot_used [SLOTS];
    ppfm_pkg::ref_t       slot_ref [SLOTS];
    ppfm_pkg::coord_t     slot_pos [SLOTS];
    bit                   slot_rev [SLOTS];
    ppfm_pkg::ppfm_pair_t pending_pairs [$];
    int                   errors;

    function new();
      min_gap = '0;
      errors  = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void set_min_gap(ppfm_pkg::coord_t v);
      min_gap = v;
    endfunction

    function int pending();
      return pending_pairs.size();
    endfunction

    // circular fragments take the two end pieces of the genome
    function bit covers(longint p, longint s, longint e, bit circ);
      if (circ) return (p >= s) || (p <= e);
      return (p >= s) && (p <= e);
    endfunction

    // reduce modulo genome length, a zero remainder shows as the length
    function ppfm_pkg::coord_t fold(longint x, longint len);
      longint r;
      if (len == 0) return ppfm_pkg::coord_t'(x);
      r = x % len;
      return ppfm_pkg::coord_t'((r != 0) ? r : len);
    endfunction

    function void note_request(ppfm_pkg::ppfm_req_t r);
      longint               s, e, len, fpos, rpos, span;
      bit                   circ, has_fwd, has_rev, dropped;
      int                   n_fwd, n_rev;
      ppfm_pkg::ppfm_pair_t found [$];
      ppfm_pkg::ppfm_pair_t p;
      if (r.req_type == ppfm_pkg::REQ_LOAD) begin
        slot_used[r.primer_slot] = 1'b1;
        slot_ref[r.primer_slot]  = r.primer_ref;
        slot_rev[r.primer_slot]  = r.primer_is_reverse;
        slot_pos[r.primer_slot]  = r.primer_is_reverse ? r.primer_start : r.primer_end;
        return;
      end
      s    = longint'(r.frag_start);
      e    = longint'(r.frag_end);
      len  = longint'(r.ref_len);
      circ = (s > e);
      if (circ) begin
        if (s == 0) s = len;
        if (e == 0) e = 1;
      end
      has_fwd = 1'b0;
      has_rev = 1'b0;
      dropped = 1'b0;
      foreach (slot_used[i]) begin
        if (slot_used[i] && slot_ref[i] == r.frag_ref) begin
          if (slot_rev[i]) has_rev = 1'b1;
          else has_fwd = 1'b1;
        end
      end
      n_fwd = has_fwd ? SLOTS : 1;
      n_rev = has_rev ? SLOTS : 1;
      // forward primers outer, reverse inner, both in slot order
      for (int i = 0; i < n_fwd; i++) begin
        if (has_fwd) begin
          if (!slot_used[i] || slot_rev[i] || slot_ref[i] != r.frag_ref) continue;
          fpos = longint'(slot_pos[i]);
        end else begin
          fpos = s;
        end
        if (!covers(fpos, s, e, circ)) continue;
        for (int j = 0; j < n_rev; j++) begin
          if (has_rev) begin
            if (!slot_used[j] || !slot_rev[j] || slot_ref[j] != r.frag_ref) continue;
            rpos = longint'(slot_pos[j]);
          end else begin
            rpos = e;
          end
          if (!covers(rpos, s, e, circ)) continue;
          if (circ && fpos > rpos) rpos += len;
          span = rpos - fpos;
          if (span < 0) span += len;
          if (span < 0 || span < longint'(min_gap)) continue;
          if (found.size() >= PAIR_CAP) begin
            dropped = 1'b1;
            continue;
          end
          p.out_tag       = r.frag_tag;
          p.fwd_pos       = fold(fpos, len);
          p.rev_pos       = fold(rpos, len);
          p.gap           = ppfm_pkg::gap_t'(span);
          p.last_pair     = 1'b0;
          p.pairs_dropped = 1'b0;
          found = {found, p};
        end
      end
      foreach (found[k]) begin
        found[k].pairs_dropped = dropped;
        found[k].last_pair     = (k == found.size() - 1);
        pending_pairs = {pending_pairs, found[k]};
      end
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_pair(ppfm_pkg::ppfm_pair_t got);
      ppfm_pkg::ppfm_pair_t want;
      if (pending_pairs.size() == 0) begin
        errors++;
        $display("%0t: pair beat with none expected, got %p", $time, got);
        return;
      end
      want = pending_pairs.pop_front();
      compare_field("out_tag", want.out_tag, got.out_tag);
      compare_field("fwd_pos", want.fwd_pos, got.fwd_pos);
      compare_field("rev_pos", want.rev_pos, got.rev_pos);
      compare_field("gap", want.gap, got.gap);
      compare_field("last_pair", want.last_pair, got.last_pair);
      compare_field("pairs_dropped", want.pairs_dropped, got.pairs_dropped);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  ppfm_pkg::ppfm_req_t  req = '0;
  logic                 pair_valid;
  logic                 pair_stall = 1'b0;
  ppfm_pkg::ppfm_pair_t pair;
  logic                 cfg_wr_en = 1'b0;
  ppfm_pkg::coord_t     cfg_wr_data = '0;

  pair_scoreboard board = new();
  int  sent_items = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_request = 1'b0;

  primer_pair_fragment_match dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .pair       (pair),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pair side: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        pair_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        pair_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pair_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        pair_stall <= 1'b0;
      end else begin
        pair_stall <= 1'b0;
      end
    end
  end

  // check every accepted pair beat
  always @(posedge clk) begin
    if (!rst && pair_valid && !pair_stall) board.check_pair(pair);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (pair_valid && !pair_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("primer_pair_fragment_match: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // all fields random; callers override the ones that matter
  function automatic ppfm_pkg::ppfm_req_t noise_item();
    ppfm_pkg::ppfm_req_t r;
    r.req_type          = ppfm_pkg::req_kind_t'($urandom_range(0, 1));
    r.primer_slot       = ppfm_pkg::SLOT_BITS'($urandom_range(0, SLOTS - 1));
    r.primer_ref        = ppfm_pkg::ref_t'($urandom_range(0, 255));
    r.primer_start      = ppfm_pkg::coord_t'($urandom_range(0, COORD_MAX));
    r.primer_end        = ppfm_pkg::coord_t'($urandom_range(0, COORD_MAX));
    r.primer_is_reverse = 1'($urandom_range(0, 1));
    r.frag_ref          = ppfm_pkg::ref_t'($urandom_range(0, 255));
    r.frag_start        = ppfm_pkg::coord_t'($urandom_range(0, COORD_MAX));
    r.frag_end          = ppfm_pkg::coord_t'($urandom_range(0, COORD_MAX));
    r.ref_len           = ppfm_pkg::coord_t'($urandom_range(1, COORD_MAX));
    r.frag_tag          = ppfm_pkg::tag_t'($urandom_range(0, 65535));
    return r;
  endfunction

  // drive one request beat, held until accepted
  task automatic send_item(ppfm_pkg::ppfm_req_t item);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    board.note_request(item);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_load(int slot, int sref, int rev, int pos);
    ppfm_pkg::ppfm_req_t r;
    r                   = noise_item();
    r.req_type          = ppfm_pkg::REQ_LOAD;
    r.primer_slot       = ppfm_pkg::SLOT_BITS'(slot);
    r.primer_ref        = ppfm_pkg::ref_t'(sref);
    r.primer_is_reverse = 1'(rev);
    if (rev != 0) r.primer_start = ppfm_pkg::coord_t'(pos);
    else r.primer_end = ppfm_pkg::coord_t'(pos);
    send_item(r);
  endtask

  task automatic send_frag(int fref, int s, int e, int len);
    ppfm_pkg::ppfm_req_t r;
    r            = noise_item();
    r.req_type   = ppfm_pkg::REQ_QUERY;
    r.frag_ref   = ppfm_pkg::ref_t'(fref);
    r.frag_start = ppfm_pkg::coord_t'(s);
    r.frag_end   = ppfm_pkg::coord_t'(e);
    r.ref_len    = ppfm_pkg::coord_t'(len);
    send_item(r);
  endtask

  // stop offering, wait for all pairs, then let a query walk finish
  task automatic drain();
    req_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_min_gap(int v);
    cfg_wr_data <= ppfm_pkg::coord_t'(v);
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_min_gap(ppfm_pkg::coord_t'(v));
    @(negedge clk);
  endtask

  // a few primers on one reference, then queries on that reference around them
  task automatic run_session();
    int  sref, base, s, e, len, pos;
    bit  circ;
    sref = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 255);
    circ = ($urandom_range(0, 3) == 0);
    if (circ) begin
      len = $urandom_range(1000, COORD_MAX);
      s   = len - $urandom_range(1, 300);
      e   = $urandom_range(0, 300);
    end else begin
      base = $urandom_range(0, COORD_MAX - 600);
      s    = base + $urandom_range(0, 40);
      e    = s + $urandom_range(0, 300);
      len  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 400)
                                         : $urandom_range(1, COORD_MAX);
    end
    repeat ($urandom_range(1, 5)) begin
      if (circ)
        pos = $urandom_range(0, 1) ? s - 10 + $urandom_range(0, len - s + 20)
                                   : $urandom_range(0, e + 20);
      else
        pos = s - 20 + $urandom_range(0, e - s + 40);
      send_load($urandom_range(0, SLOTS - 1), sref, $urandom_range(0, 1), pos);
    end
    repeat ($urandom_range(1, 3)) begin
      if (circ) send_frag(sref, s, ($urandom_range(0, 4) == 0) ? 0 : e, len);
      else send_frag(sref, s + $urandom_range(0, 20), e, len);
    end
  endtask

  // every slot on one reference: far more pairs than the cap
  task automatic run_full_table();
    int sref, base;
    sref = $urandom_range(8, 255);
    base = $urandom_range(0, COORD_MAX - 400);
    for (int k = 0; k < SLOTS; k++) begin
      if (k % 2 == 1) send_load(k, sref, 1, base + 150 + $urandom_range(0, 50));
      else send_load(k, sref, 0, base + $urandom_range(0, 50));
    end
    hold_request = 1'b1;
    send_frag(sref, base, base + 300, $urandom_range(1, COORD_MAX));
  endtask

  task automatic run_phase();
    int target;
    target = sent_items + PHASE_ITEMS;
    while (sent_items < target) begin
      if ($urandom_range(0, 9) == 0) send_item(noise_item());
      else run_session();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, min gap at its reset value of zero
    send_frag(7, 100, 200, 1000);            // empty table: start and end stand in
    send_load(0, 7, 0, 120);
    send_load(1, 7, 1, 180);
    send_load(2, 7, 0, 150);
    send_load(3, 7, 1, 130);                 // reverse ahead of a forward primer
    send_frag(7, 100, 200, 1000);            // negative gap fixed by one genome length
    send_frag(7, 100, 200, 15);              // still negative, plus reduction
    send_load(0, 7, 0, 300);                 // overwrite, now outside
    send_frag(7, 100, 200, 1000);
    send_load(4, 9, 0, 10);
    send_frag(9, 5, 50, 60);                 // no reverse primer: end stands in
    send_frag(9, 20, 50, 60);                // forward primer outside: no pair
    send_load(5, 11, 1, 40);
    send_frag(11, 5, 50, 60);                // no forward primer: start stands in
    send_load(6, 12, 0, 900);
    send_load(7, 12, 1, 30);
    send_frag(12, 800, 50, 1000);            // circular, reverse wraps
    send_frag(13, 500, 0, 600);              // circular with end of zero
    send_load(31, 255, 0, 0);
    send_load(30, 255, 1, COORD_MAX);
    send_frag(255, 0, COORD_MAX, COORD_MAX); // extreme coordinates
    send_frag(0, COORD_MAX, COORD_MAX, 1);   // genome length of one

    // largest min gap: only the full-span pair passes
    drain();
    write_min_gap(COORD_MAX);
    send_frag(255, 0, COORD_MAX, COORD_MAX);
    send_frag(7, 100, 200, 1000);

    drain();
    write_min_gap(0);
    run_full_table();
    run_phase();

    drain();
    write_min_gap($urandom_range(1, 60));
    run_phase();

    drain();
    write_min_gap($urandom_range(0, COORD_MAX));
    run_phase();

    drain();
    write_min_gap($urandom_range(1, 8));
    run_phase();

    // closing stretch without idling on either side
    drain();
    quiet = 1'b1;
    write_min_gap(1);
    run_phase();

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("primer_pair_fragment_match: match");
    end else begin
      $display("primer_pair_fragment_match: mismatch");
    end
    $finish;
  end

endmodule

[primer_pair_fragment_match.f]
rtl/ppfm_pkg.sv
rtl/primer_pair_fragment_match.sv
rtl/ppfm_checker.sv
sim/tb.sv
